// ===== sv/sbt_pkg.sv =====
// Package: token kinds, lexer modes and shared request types of the tokenizer.
package sbt_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE       = 4'd0,
		MODE_IDENT      = 4'd1,
		MODE_NUM_INT    = 4'd2,
		MODE_NUM_FRAC   = 4'd3,
		MODE_STRING     = 4'd4,
		MODE_PEND_MINUS = 4'd5,
		MODE_PEND_SLASH = 4'd6,
		MODE_COMMENT    = 4'd7,
		MODE_CMT_STAR   = 4'd8
	} lex_mode_t;

	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_IDENT   = 5'd1;
	localparam logic [4:0] KIND_FN      = 5'd2;
	localparam logic [4:0] KIND_STRING  = 5'd8;
	localparam logic [4:0] KIND_NUMBER  = 5'd9;
	localparam logic [4:0] KIND_LBRACE  = 5'd10;
	localparam logic [4:0] KIND_RBRACE  = 5'd11;
	localparam logic [4:0] KIND_LPAREN  = 5'd12;
	localparam logic [4:0] KIND_RPAREN  = 5'd13;
	localparam logic [4:0] KIND_LBRACK  = 5'd14;
	localparam logic [4:0] KIND_RBRACK  = 5'd15;
	localparam logic [4:0] KIND_SEMI    = 5'd16;
	localparam logic [4:0] KIND_COLON   = 5'd17;
	localparam logic [4:0] KIND_DOT     = 5'd18;
	localparam logic [4:0] KIND_COMMA   = 5'd19;
	localparam logic [4:0] KIND_HASH    = 5'd20;
	localparam logic [4:0] KIND_PLUS    = 5'd21;
	localparam logic [4:0] KIND_MINUS   = 5'd22;
	localparam logic [4:0] KIND_MUL     = 5'd23;
	localparam logic [4:0] KIND_DIV     = 5'd24;
	localparam logic [4:0] KIND_ASSIGN  = 5'd25;
	localparam logic [4:0] KIND_ARROW   = 5'd26;
	localparam logic [4:0] KIND_UNKNOWN = 5'd27;

	localparam int NUM_KW = 6;
	localparam int KW_MAXLEN = 6;

	// Byte classes found by the front end.
	typedef struct packed {
		logic       is_eof;
		logic       is_blank;
		logic       is_newline;
		logic       is_alpha;
		logic       is_digit;
		logic       is_dot;
		logic       is_quote;
		logic       is_minus;
		logic       is_slash;
		logic       is_star;
		logic       is_gt;
		logic [4:0] single_kind;
	} byte_class_t;

	function automatic logic [7:0] kw_char(input int k, input int p);
		logic [7:0] c;
		c = 8'h00;
		case (k)
			0: case (p) 0: c = "f"; 1: c = "n"; default: c = 8'h00; endcase
			1: case (p) 0: c = "r"; 1: c = "e"; 2: c = "t"; 3: c = "u"; 4: c = "r";
				5: c = "n"; default: c = 8'h00; endcase
			2: case (p) 0: c = "s"; 1: c = "t"; 2: c = "r"; 3: c = "u"; 4: c = "c";
				5: c = "t"; default: c = 8'h00; endcase
			3: case (p) 0: c = "e"; 1: c = "n"; 2: c = "u"; 3: c = "m";
				default: c = 8'h00; endcase
			4: case (p) 0: c = "u"; 1: c = "3"; 2: c = "2"; default: c = 8'h00; endcase
			5: case (p) 0: c = "s"; 1: c = "3"; 2: c = "2"; default: c = 8'h00; endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] kw_len(input int k);
		logic [2:0] l;
		case (k)
			0: l = 3'd2;
			1: l = 3'd6;
			2: l = 3'd6;
			3: l = 3'd4;
			default: l = 3'd3;
		endcase
		return l;
	endfunction

	function automatic byte_class_t classify(input logic [7:0] c);
		byte_class_t b;
		b = '0;
		b.is_eof     = (c == 8'h00);
		b.is_newline = (c == 8'h0A);
		b.is_blank   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
		b.is_alpha   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
		b.is_digit   = (c >= "0" && c <= "9");
		b.is_dot     = (c == ".");
		b.is_quote   = (c == 8'h22);
		b.is_minus   = (c == "-");
		b.is_slash   = (c == "/");
		b.is_star    = (c == "*");
		b.is_gt      = (c == ">");
		case (c)
			"{": b.single_kind = KIND_LBRACE;
			"}": b.single_kind = KIND_RBRACE;
			"(": b.single_kind = KIND_LPAREN;
			")": b.single_kind = KIND_RPAREN;
			"[": b.single_kind = KIND_LBRACK;
			"]": b.single_kind = KIND_RBRACK;
			";": b.single_kind = KIND_SEMI;
			":": b.single_kind = KIND_COLON;
			".": b.single_kind = KIND_DOT;
			",": b.single_kind = KIND_COMMA;
			"#": b.single_kind = KIND_HASH;
			"+": b.single_kind = KIND_PLUS;
			"*": b.single_kind = KIND_MUL;
			"=": b.single_kind = KIND_ASSIGN;
			default: b.single_kind = KIND_EOF;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/sbt_front.sv =====
// Front end: accept bytes, classify them and push requests into a short queue.
module sbt_front #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  logic [7:0]          src_byte,
	output logic                req_valid,
	input  logic                req_take,
	output logic [7:0]          req_byte,
	output sbt_pkg::byte_class_t req_class
);
	import sbt_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [7:0]  byte_mem [DEPTH];
	byte_class_t cls_mem  [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop;

	assign src_stall = (cnt_q == (AW+1)'(DEPTH));
	assign push = src_valid && !src_stall;
	assign pop  = req_take && (cnt_q != '0);
	assign req_valid = (cnt_q != '0);
	assign req_byte  = byte_mem[rd_q];
	assign req_class = cls_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			byte_mem[wr_q] <= src_byte;
			cls_mem[wr_q]  <= classify(src_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= AW'((32'(wr_q) + 1) % DEPTH);
			if (pop)  rd_q <= AW'((32'(rd_q) + 1) % DEPTH);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (AW+1)'(DEPTH)) |-> !push) else $error("push into full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> req_valid) else $error("pop from empty queue");

endmodule

// ===== sv/sbt_back.sv =====
// Back end: lexer state machine, position counters and a four-entry result queue.
module sbt_back #(
	parameter int LW = 16,
	parameter int CW = 12,
	parameter int NW = 12,
	parameter int OW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_take,
	input  logic [7:0]           req_byte,
	input  sbt_pkg::byte_class_t req_class,
	output logic                 tok_valid,
	input  logic                 tok_stall,
	output logic [4:0]           token_kind,
	output logic [LW-1:0]        start_line,
	output logic [CW-1:0]        start_column,
	output logic [OW-1:0]        start_offset,
	output logic [NW-1:0]        text_length,
	output logic                 last_of_run
);
	import sbt_pkg::*;

	typedef struct packed {
		logic [4:0]    kind;
		logic [LW-1:0] line;
		logic [CW-1:0] col;
		logic [OW-1:0] off;
		logic [NW-1:0] len;
		logic          last;
	} tok_t;

	localparam int QD = 4;

	lex_mode_t     mode_q, mode_d;
	logic [LW-1:0] cur_line_q, tok_line_q, tok_line_d;
	logic [CW-1:0] cur_col_q, tok_col_q, tok_col_d;
	logic [OW-1:0] cur_off_q, tok_off_q, tok_off_d;
	logic [NW-1:0] tok_len_q, tok_len_d;
	logic [NUM_KW-1:0] kw_q, kw_d;

	tok_t q_mem [QD];
	logic [1:0] qw_q, qr_q;
	logic [2:0] qc_q;

	tok_t r0, r1;
	logic e0, e1, again, step;
	byte_class_t b;
	logic [7:0] c;
	logic [4:0] id_kind;
	logic [NW-1:0] len_inc;
	logic [OW-1:0] off_inc;

	assign b = req_class;
	assign c = req_byte;
	// Take a request only when two result slots are free.
	assign req_take = (qc_q <= 3'd2);
	assign step = req_valid && req_take;
	assign len_inc = (tok_len_q == '1) ? tok_len_q : tok_len_q + NW'(1);
	assign off_inc = (cur_off_q == '1) ? cur_off_q : cur_off_q + OW'(1);

	always_comb begin
		id_kind = KIND_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (kw_q[k] && tok_len_q == NW'(kw_len(k))) id_kind = KIND_FN + 5'(k);
		end
	end

	function automatic tok_t mk(input logic [4:0] k, input logic [LW-1:0] l,
			input logic [CW-1:0] cc, input logic [OW-1:0] o, input logic [NW-1:0] n);
		tok_t t;
		t.kind = k; t.line = l; t.col = cc; t.off = o; t.len = n; t.last = 1'b0;
		return t;
	endfunction

	always_comb begin
		mode_d = mode_q;
		tok_line_d = tok_line_q;
		tok_col_d = tok_col_q;
		tok_off_d = tok_off_q;
		tok_len_d = tok_len_q;
		kw_d = kw_q;
		e0 = 1'b0;
		e1 = 1'b0;
		again = 1'b0;
		r0 = mk(KIND_EOF, tok_line_q, tok_col_q, tok_off_q, tok_len_q);
		r1 = mk(KIND_EOF, cur_line_q, cur_col_q, cur_off_q, NW'(1));
		case (mode_q)
			MODE_IDENT: begin
				if (b.is_alpha || b.is_digit) begin
					for (int k = 0; k < NUM_KW; k++) begin
						if (tok_len_q >= NW'(kw_len(k)) || tok_len_q >= NW'(KW_MAXLEN) ||
								kw_char(k, int'(tok_len_q[2:0])) != c)
							kw_d[k] = 1'b0;
					end
					tok_len_d = len_inc;
				end else begin
					e0 = 1'b1; r0.kind = id_kind; again = 1'b1;
				end
			end
			MODE_NUM_INT: begin
				if (b.is_digit) tok_len_d = len_inc;
				else if (b.is_dot) begin
					tok_len_d = len_inc; mode_d = MODE_NUM_FRAC;
				end else begin
					e0 = 1'b1; r0.kind = KIND_NUMBER; again = 1'b1;
				end
			end
			MODE_NUM_FRAC: begin
				if (b.is_digit) tok_len_d = len_inc;
				else begin
					e0 = 1'b1; r0.kind = KIND_NUMBER; again = 1'b1;
				end
			end
			MODE_STRING: begin
				if (b.is_eof) again = 1'b1;
				else if (b.is_quote) begin
					e0 = 1'b1; r0.kind = KIND_STRING; mode_d = MODE_IDLE;
				end else tok_len_d = len_inc;
			end
			MODE_PEND_MINUS: begin
				if (b.is_gt) begin
					e0 = 1'b1; r0.kind = KIND_ARROW; r0.len = NW'(2); mode_d = MODE_IDLE;
				end else begin
					e0 = 1'b1; r0.kind = KIND_MINUS; again = 1'b1;
				end
			end
			MODE_PEND_SLASH: begin
				if (b.is_star) mode_d = MODE_COMMENT;
				else begin
					e0 = 1'b1; r0.kind = KIND_DIV; again = 1'b1;
				end
			end
			MODE_COMMENT: begin
				if (b.is_eof) again = 1'b1;
				else if (b.is_star) mode_d = MODE_CMT_STAR;
			end
			MODE_CMT_STAR: begin
				if (b.is_eof) again = 1'b1;
				else if (b.is_slash) mode_d = MODE_IDLE;
				else if (!b.is_star) mode_d = MODE_COMMENT;
			end
			default: again = 1'b1;
		endcase

		if (again) begin
			mode_d = MODE_IDLE;
			if (b.is_eof) begin
				e1 = 1'b1; r1.kind = KIND_EOF; r1.len = '0;
			end else if (b.is_blank) begin
			end else if (b.single_kind != KIND_EOF) begin
				e1 = 1'b1; r1.kind = b.single_kind;
			end else if (b.is_minus || b.is_slash || b.is_digit || b.is_alpha || b.is_quote) begin
				tok_line_d = cur_line_q;
				tok_col_d = cur_col_q;
				tok_off_d = cur_off_q;
				tok_len_d = NW'(1);
				if (b.is_minus) mode_d = MODE_PEND_MINUS;
				else if (b.is_slash) mode_d = MODE_PEND_SLASH;
				else if (b.is_digit) mode_d = MODE_NUM_INT;
				else if (b.is_quote) begin
					tok_off_d = off_inc; tok_len_d = '0; mode_d = MODE_STRING;
				end else begin
					mode_d = MODE_IDENT;
					for (int k = 0; k < NUM_KW; k++) kw_d[k] = (kw_char(k, 0) == c);
				end
			end else begin
				e1 = 1'b1; r1.kind = KIND_UNKNOWN;
			end
		end
		if (e1) r1.last = 1'b1;
		else r0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cur_line_q <= '0; cur_col_q <= '0; cur_off_q <= '0;
			tok_line_q <= '0; tok_col_q <= '0; tok_off_q <= '0; tok_len_q <= '0;
			kw_q <= '1;
		end else if (step) begin
			if (b.is_eof) begin
				// End of stream: return to reset values.
				mode_q <= MODE_IDLE;
				cur_line_q <= '0; cur_col_q <= '0; cur_off_q <= '0;
				tok_line_q <= '0; tok_col_q <= '0; tok_off_q <= '0; tok_len_q <= '0;
				kw_q <= '1;
			end else begin
				mode_q <= mode_d;
				tok_line_q <= tok_line_d; tok_col_q <= tok_col_d;
				tok_off_q <= tok_off_d; tok_len_q <= tok_len_d;
				kw_q <= kw_d;
				cur_off_q <= off_inc;
				if (b.is_newline) begin
					cur_line_q <= (cur_line_q == '1) ? cur_line_q : cur_line_q + LW'(1);
					cur_col_q <= '0;
				end else begin
					cur_col_q <= (cur_col_q == '1) ? cur_col_q : cur_col_q + CW'(1);
				end
			end
		end
	end

	// Result queue: up to two pushes per request, one pop per cycle while tok_stall is low.
	logic do_pop;
	logic [1:0] npush;
	assign tok_valid = (qc_q != '0);
	assign do_pop = tok_valid && !tok_stall;
	assign npush = step ? (2'(e0) + 2'(e1)) : 2'd0;
	assign {token_kind, start_line, start_column, start_offset, text_length, last_of_run}
		= q_mem[qr_q];

	always_ff @(posedge clk) begin
		if (step && e0) q_mem[qw_q] <= r0;
		if (step && e1) q_mem[qw_q + 2'(e0)] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= '0; qr_q <= '0; qc_q <= '0;
		end else begin
			qw_q <= qw_q + npush;
			if (do_pop) qr_q <= qr_q + 2'd1;
			qc_q <= qc_q + 3'(npush) - 3'(do_pop);
		end
	end

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qc_q <= 3'd4) else $error("result queue overflow");
	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step && b.is_eof) |=> (mode_q == MODE_IDLE && cur_off_q == '0))
		else $error("state not cleared after end of stream");
	a_eof_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(step && b.is_eof) |-> e1) else $error("end of stream without eof token");

endmodule

// ===== sv/source_byte_tokenizer.sv =====
// Top level of the streaming source byte tokenizer.
// Usage:
//  - Input channel src_valid / src_stall / src_byte: one source byte per request.
//    A zero byte ends the stream; the lexer then returns to its reset state, so a
//    new stream may follow at once.
//  - Output channel tok_valid / tok_stall with token fields: one token per request.
//    A byte yields zero, one or two tokens; last_of_run marks the final one.
//  - Throughput: one byte per cycle while results drain; the back end lexer
//    handles one byte per cycle while the result queue has two free slots, and the
//    two-token worst case is absorbed by a four-entry result queue, so a sustained
//    stream of double-token bytes is limited by the single output port.
//  - Order: an accepted byte is first registered in the front queue; the lexer
//    takes it from there when the result queue has room, and its tokens are
//    registered in the result queue before they are shown on the output.
//  - Reset (arst_n low) empties both queues and clears line, column, offset and
//    the pending token.
//  - When tok_stall is high, results hold in the queue; once it holds more than
//    two tokens, the lexer stops taking requests, then the front queue fills and
//    src_stall rises.
module source_byte_tokenizer #(
	parameter int LINE_WIDTH   = 16,
	parameter int COLUMN_WIDTH = 12,
	parameter int LENGTH_WIDTH = 12,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    src_valid,
	output logic                    src_stall,
	input  logic [7:0]              src_byte,
	output logic                    tok_valid,
	input  logic                    tok_stall,
	output logic [4:0]              token_kind,
	output logic [LINE_WIDTH-1:0]   start_line,
	output logic [COLUMN_WIDTH-1:0] start_column,
	output logic [OFFSET_WIDTH-1:0] start_offset,
	output logic [LENGTH_WIDTH-1:0] text_length,
	output logic                    last_of_run
);
	import sbt_pkg::*;

	logic        req_valid, req_take;
	logic [7:0]  req_byte;
	byte_class_t req_class;

	// Front: hold accepted bytes with their class in a short queue.
	sbt_front #(.DEPTH(4)) u_front (
		.clk, .arst_n, .src_valid, .src_stall, .src_byte,
		.req_valid, .req_take, .req_byte, .req_class
	);

	// Back: advance the lexer and queue the tokens.
	sbt_back #(
		.LW(LINE_WIDTH), .CW(COLUMN_WIDTH), .NW(LENGTH_WIDTH), .OW(OFFSET_WIDTH)
	) u_back (
		.clk, .arst_n, .req_valid, .req_take, .req_byte, .req_class,
		.tok_valid, .tok_stall, .token_kind, .start_line, .start_column,
		.start_offset, .text_length, .last_of_run
	);

endmodule
